>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the clocked assertions of the statistics block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and off while i_rst_n is low.
`define MSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk and off while i_rst_n is low.
`define MSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Output field widths, default sizes and shared types of the mean and
// standard deviation block.
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int MEAN_W = 24;
    localparam int STD_W  = 23;
    localparam int CNT_W  = 13;

    localparam int DEF_MAX_SAMPLES   = 4096;
    localparam int DEF_SAMPLE_BITS   = 16;
    localparam int DEF_FRACTION_BITS = 8;

    typedef struct packed {
        logic set_ready;
        logic overflow;
    } t_acc_status;

endpackage

>>> rtl/mean_std_dev.sv
// ----------------------------------------------------------------------------
// mean_std_dev
// Population mean and standard deviation of a set of signed samples, in
// fixed point with FRACTION_BITS fractional bits.
//
//   channel   dir  ports                                  transfer
//   sample    in   i_sample, i_last_sample                start & !busy
//   result    out  o_mean_value, o_std_dev,               o_done, one cycle
//                  o_sample_count, o_count_overflow
//
// A sample without the last flag leaves busy low; the next may follow at once.
// The last sample of a set raises busy through the bit-serial products n*Q and
// S*S, the root alongside the division for the mean, and the division of the
// root by the count; the result is out in the first cycle with busy low.
// Reset is synchronous and active low and empties the accumulators.
// The receiver cannot stall: o_done is high for exactly one cycle per set.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mean_std_dev #(
    parameter int MAX_SAMPLES   = msd_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS   = msd_pkg::DEF_SAMPLE_BITS,
    parameter int FRACTION_BITS = msd_pkg::DEF_FRACTION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last_sample,
    output logic                          o_done,
    output logic signed [msd_pkg::MEAN_W-1:0] o_mean_value,
    output logic [msd_pkg::STD_W-1:0]     o_std_dev,
    output logic [msd_pkg::CNT_W-1:0]     o_sample_count,
    output logic                          o_count_overflow
);
    import msd_pkg::*;

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SW  = CW + SAMPLE_BITS - 1;
    localparam int QW  = CW + 2 * SAMPLE_BITS - 2;
    localparam int VW  = 2 * SW;
    localparam int VEW = VW + 2 * FRACTION_BITS;
    localparam int RW  = VEW / 2;
    localparam int MNW = SW + FRACTION_BITS;
    localparam int DW  = (MNW > RW) ? MNW : RW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUB,
        S_ROOT,
        S_DEV
    } t_state;

    t_state             r_state;
    logic               r_busy;
    logic               r_done;
    logic               r_mul_go;
    logic               r_sqrt_go;
    logic               r_div_go;
    logic               r_nq_ok;
    logic               r_ss_ok;
    logic               r_mean_ok;
    logic               r_root_ok;
    logic [VW-1:0]      r_var;
    logic [DW-1:0]      r_mean;
    logic signed [MEAN_W-1:0] r_mean_out;
    logic [STD_W-1:0]   r_std_out;
    logic [CNT_W-1:0]   r_cnt_out;
    logic               r_ovf_out;

    logic               w_accept;
    logic               w_clear;
    logic signed [SW:0] w_sum;
    logic [QW-1:0]      w_sq_sum;
    logic [CW-1:0]      w_count;
    t_acc_status        w_status;
    logic [SW-1:0]      w_smag;
    logic               w_nq_done;
    logic               w_ss_done;
    logic [VW-1:0]      w_nq;
    logic [VW-1:0]      w_ss;
    logic               w_root_done;
    logic [RW-1:0]      w_root;
    logic               w_div_done;
    logic [DW-1:0]      w_div_num;
    logic [DW-1:0]      w_quot;
    logic signed [DW:0] w_mean_s;

    assign w_accept = start & ~r_busy;
    assign w_clear  = (r_state == S_DEV) && w_div_done;
    assign w_smag   = w_sum[SW] ? SW'(-w_sum) : SW'(w_sum);

    // The shared divider first takes the scaled sum, then the root.
    assign w_div_num = (r_state == S_DEV) ? DW'(w_root)
                                          : (DW'(w_smag) << FRACTION_BITS);
    assign w_mean_s  = w_sum[SW] ? -$signed({1'b0, r_mean}) : $signed({1'b0, r_mean});

    msd_accum #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_accept),
        .i_sample (i_sample),
        .i_last   (i_last_sample),
        .i_clear  (w_clear),
        .o_sum    (w_sum),
        .o_sq_sum (w_sq_sum),
        .o_count  (w_count),
        .o_status (w_status)
    );

    msd_mul #(
        .AW (QW),
        .BW (CW)
    ) u_mul_nq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (w_sq_sum),
        .i_b     (w_count),
        .o_done  (w_nq_done),
        .o_prod  (w_nq)
    );

    msd_mul #(
        .AW (SW),
        .BW (SW)
    ) u_mul_ss (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (w_smag),
        .i_b     (w_smag),
        .o_done  (w_ss_done),
        .o_prod  (w_ss)
    );

    msd_sqrt #(
        .RW (RW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sqrt_go),
        .i_rad   (VEW'(r_var) << (2 * FRACTION_BITS)),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    msd_div #(
        .DW (DW),
        .NW (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (w_div_num),
        .i_den   (w_count),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_mul_go  <= 1'b0;
            r_sqrt_go <= 1'b0;
            r_div_go  <= 1'b0;
            r_nq_ok   <= 1'b0;
            r_ss_ok   <= 1'b0;
            r_mean_ok <= 1'b0;
            r_root_ok <= 1'b0;
        end else begin
            r_done    <= 1'b0;
            r_mul_go  <= 1'b0;
            r_sqrt_go <= 1'b0;
            r_div_go  <= 1'b0;
            if (w_accept && i_last_sample) begin
                r_busy <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_status.set_ready) begin
                        r_mul_go <= 1'b1;
                        r_nq_ok  <= 1'b0;
                        r_ss_ok  <= 1'b0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (w_nq_done) begin
                        r_nq_ok <= 1'b1;
                    end
                    if (w_ss_done) begin
                        r_ss_ok <= 1'b1;
                    end
                    if ((r_nq_ok || w_nq_done) && (r_ss_ok || w_ss_done)) begin
                        r_state <= S_SUB;
                    end
                end
                S_SUB: begin
                    // n*Q - S*S is never negative for real data.
                    r_var     <= w_nq - w_ss;
                    r_sqrt_go <= 1'b1;
                    r_div_go  <= 1'b1;
                    r_mean_ok <= 1'b0;
                    r_root_ok <= 1'b0;
                    r_state   <= S_ROOT;
                end
                S_ROOT: begin
                    if (w_div_done) begin
                        r_mean    <= w_quot;
                        r_mean_ok <= 1'b1;
                    end
                    if (w_root_done) begin
                        r_root_ok <= 1'b1;
                    end
                    if ((r_mean_ok || w_div_done) && (r_root_ok || w_root_done)) begin
                        r_div_go <= 1'b1;
                        r_state  <= S_DEV;
                    end
                end
                S_DEV: begin
                    if (w_div_done) begin
                        r_mean_out <= MEAN_W'(w_mean_s);
                        r_std_out  <= STD_W'(w_quot);
                        r_cnt_out  <= CNT_W'(w_count);
                        r_ovf_out  <= w_status.overflow;
                        r_done     <= 1'b1;
                        r_busy     <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy             = r_busy;
    assign o_done           = r_done;
    assign o_mean_value     = r_mean_out;
    assign o_std_dev        = r_std_out;
    assign o_sample_count   = r_cnt_out;
    assign o_count_overflow = r_ovf_out;

    `MSD_ASSERT_NOW(a_active_busy, r_state != S_IDLE, r_busy, "sequencer active while not busy")
    `MSD_ASSERT_NEXT(a_done_pulse, r_done, !r_done, "result strobe longer than one cycle")
    `MSD_ASSERT_NOW(a_done_free, r_done, !r_busy, "busy still high with result out")

endmodule

>>> rtl/msd_accum.sv
// ----------------------------------------------------------------------------
// msd_accum
// Squares each sample and keeps the count, running sum and running sum of
// squares of the current set.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msd_accum #(
    parameter int MAX_SAMPLES = msd_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = msd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_take,
    input  logic signed [SAMPLE_BITS-1:0]           i_sample,
    input  logic                                    i_last,
    input  logic                                    i_clear,
    output logic signed [$clog2(MAX_SAMPLES+1)+SAMPLE_BITS-1:0] o_sum,
    output logic [$clog2(MAX_SAMPLES+1)+2*SAMPLE_BITS-3:0]      o_sq_sum,
    output logic [$clog2(MAX_SAMPLES+1)-1:0]        o_count,
    output msd_pkg::t_acc_status                    o_status
);
    import msd_pkg::*;

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SW  = CW + SAMPLE_BITS - 1;
    localparam int QW  = CW + 2 * SAMPLE_BITS - 2;
    localparam int XQW = 2 * SAMPLE_BITS - 1;

    logic                            r_a_vld;
    logic                            r_a_last;
    logic signed [SAMPLE_BITS-1:0]   r_a_x;
    logic [XQW-1:0]                  r_a_sq;
    logic signed [2*SAMPLE_BITS-1:0] w_square;
    logic signed [SW:0]              r_sum;
    logic [QW-1:0]                   r_sq_sum;
    logic [CW-1:0]                   r_count;
    logic                            r_ovf;
    logic                            r_ready;
    logic                            w_full;

    assign w_square = i_sample * i_sample;
    assign w_full   = (r_count >= CW'(MAX_SAMPLES));

    // Stage A holds the sample and its square, stage B adds them in.
    always_ff @(posedge i_clk) begin
        r_a_x  <= i_sample;
        r_a_sq <= w_square[XQW-1:0];
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_a_last <= 1'b0;
            r_sum    <= '0;
            r_sq_sum <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_ready  <= 1'b0;
        end else begin
            r_a_vld  <= i_take;
            r_a_last <= i_take & i_last;
            if (i_clear) begin
                r_sum    <= '0;
                r_sq_sum <= '0;
                r_count  <= '0;
                r_ovf    <= 1'b0;
                r_ready  <= 1'b0;
            end else if (r_a_vld) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_sum    <= r_sum + (SW+1)'(r_a_x);
                    r_sq_sum <= r_sq_sum + QW'(r_a_sq);
                    r_count  <= r_count + 1'b1;
                end
                if (r_a_last) begin
                    r_ready <= 1'b1;
                end
            end
        end
    end

    assign o_sum              = r_sum;
    assign o_sq_sum           = r_sq_sum;
    assign o_count            = r_count;
    assign o_status.set_ready = r_ready;
    assign o_status.overflow  = r_ovf;

    `MSD_ASSERT_NOW(a_count_cap, 1'b1, r_count <= CW'(MAX_SAMPLES), "count above set limit")

endmodule

>>> rtl/msd_mul.sv
// ----------------------------------------------------------------------------
// msd_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle,
// most significant bit first.
// ----------------------------------------------------------------------------
module msd_mul #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic             o_done,
    output logic [AW+BW-1:0] o_prod
);
    localparam int PW   = AW + BW;
    localparam int CNTW = $clog2(BW + 1);

    logic [AW-1:0]   r_a;
    logic [BW-1:0]   r_b;
    logic [PW-1:0]   r_acc;
    logic [PW-1:0]   n_acc;
    logic [CNTW-1:0] r_cnt;
    logic            r_run;
    logic            r_done;

    assign n_acc = {r_acc[PW-2:0], 1'b0} + (r_b[BW-1] ? PW'(r_a) : PW'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a   <= i_a;
                r_b   <= i_b;
                r_acc <= '0;
                r_cnt <= CNTW'(BW);
                r_run <= 1'b1;
            end else if (r_run) begin
                r_acc <= n_acc;
                r_b   <= r_b << 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

>>> rtl/msd_sqrt.sv
// ----------------------------------------------------------------------------
// msd_sqrt
// Restoring integer square root, one root bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
module msd_sqrt #(
    parameter int RW = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2*RW-1:0] i_rad,
    output logic            o_done,
    output logic [RW-1:0]   o_root
);
    localparam int CNTW = $clog2(RW + 1);

    logic [2*RW-1:0] r_rad;
    logic [RW:0]     r_rem;
    logic [RW-1:0]   r_root;
    logic [RW+2:0]   w_rem_sh;
    logic [RW+2:0]   w_trial;
    logic [RW+2:0]   w_diff;
    logic            w_ge;
    logic [RW:0]     n_rem;
    logic [CNTW-1:0] r_cnt;
    logic            r_run;
    logic            r_done;

    // Remainder never exceeds twice the partial root, so RW+1 bits hold it.
    assign w_rem_sh = {r_rem, r_rad[2*RW-1 -: 2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);
    assign w_diff   = w_rem_sh - w_trial;
    assign n_rem    = w_ge ? w_diff[RW:0] : w_rem_sh[RW:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNTW'(RW);
                r_run  <= 1'b1;
            end else if (r_run) begin
                r_rad  <= r_rad << 2;
                r_rem  <= n_rem;
                r_root <= {r_root[RW-2:0], w_ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> rtl/msd_div.sv
// ----------------------------------------------------------------------------
// msd_div
// Restoring unsigned divider, one quotient bit per cycle. The quotient
// shifts in where the dividend shifts out.
// ----------------------------------------------------------------------------
module msd_div #(
    parameter int DW = 32,
    parameter int NW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_num,
    input  logic [NW-1:0] i_den,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);
    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   r_q;
    logic [NW-1:0]   r_rem;
    logic [NW-1:0]   r_den;
    logic [NW:0]     w_rem_sh;
    logic [NW:0]     w_diff;
    logic            w_ge;
    logic [NW-1:0]   n_rem;
    logic [CNTW-1:0] r_cnt;
    logic            r_run;
    logic            r_done;

    assign w_rem_sh = {r_rem, r_q[DW-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});
    assign w_diff   = w_rem_sh - {1'b0, r_den};
    assign n_rem    = w_ge ? w_diff[NW-1:0] : w_rem_sh[NW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q   <= i_num;
                r_rem <= '0;
                r_den <= i_den;
                r_cnt <= CNTW'(DW);
                r_run <= 1'b1;
            end else if (r_run) begin
                r_q   <= {r_q[DW-2:0], w_ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> dv/mean_std_dev_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mean_std_dev_test
// Self-checking bench for the mean and standard deviation block. Data sets
// are streamed in, and each result is compared with an in-bench calculation
// of the population mean and deviation. The directed cases come first: single
// samples at the range limits, small sets with known answers, and an oversized
// set. Random sets of mixed length and content follow under several levels
// of sender gaps.
// ----------------------------------------------------------------------------
module mean_std_dev_test;

    localparam int SW        = msd_pkg::DEF_SAMPLE_BITS;
    localparam int FRAC      = msd_pkg::DEF_FRACTION_BITS;
    localparam int MAXS      = msd_pkg::DEF_MAX_SAMPLES;
    localparam int MEAN_W    = msd_pkg::MEAN_W;
    localparam int STD_W     = msd_pkg::STD_W;
    localparam int CNT_W     = msd_pkg::CNT_W;
    localparam int SUM_W     = 29;
    localparam int SQ_W      = 43;
    localparam int CYCLE_CAP = 400000;
    localparam int DRAIN     = 150;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean;
        logic [STD_W-1:0]         dev;
        logic [CNT_W-1:0]         count;
        logic                     overflow;
    } t_stats;

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 last;
        logic                 pinned;
        t_stats               value;
    } t_dir_row;

    typedef enum {FL_FULL, FL_NARROW, FL_EDGE, FL_FLAT} t_set_flavor;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic signed [SW-1:0]    i_sample;
    logic                    i_last_sample;
    logic                    o_done;
    logic signed [MEAN_W-1:0] o_mean_value;
    logic [STD_W-1:0]        o_std_dev;
    logic [CNT_W-1:0]        o_sample_count;
    logic                    o_count_overflow;

    // A hand-computed result travels with its sample and replaces the
    // calculated one when that sample is transferred.
    logic                    pin_valid;
    t_stats                  pin_value;

    logic signed [SUM_W-1:0] acc_sum;
    logic [SQ_W-1:0]         acc_sqsum;
    logic [CNT_W-1:0]        acc_count;
    logic                    acc_overflow;

    t_stats                  expected_stats[$];
    t_dir_row                dir_rows[$];
    t_stats                  step_res;
    t_stats                  want;
    logic                    step_done;
    int                      fail_count;
    int                      results_seen;
    int                      samples_sent;
    int                      cycle_count;

    mean_std_dev i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_sample         (i_sample),
        .i_last_sample    (i_last_sample),
        .o_done           (o_done),
        .o_mean_value     (o_mean_value),
        .o_std_dev        (o_std_dev),
        .o_sample_count   (o_sample_count),
        .o_count_overflow (o_count_overflow)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [63:0] isqrt128(input logic [127:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        int          b;
        root = '0;
        for (b = 63; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if ({64'd0, trial} * {64'd0, trial} <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic void stats_clear();
        acc_sum      = '0;
        acc_sqsum    = '0;
        acc_count    = '0;
        acc_overflow = 1'b0;
    endfunction

    // Accumulates one sample; on the last sample of a set returns the
    // population statistics and empties the accumulators.
    function automatic void stats_step(input logic signed [SW-1:0] s, input logic last,
                                       output logic done, output t_stats res);
        longint      v;
        longint      total;
        longint      smag;
        longint      mean_mag;
        logic [12:0] n;
        logic [127:0] spread;
        v    = s;
        done = 1'b0;
        res  = '0;
        if (acc_count >= MAXS) begin
            acc_overflow = 1'b1;
        end else begin
            acc_sum   = acc_sum + SUM_W'(v);
            acc_sqsum = acc_sqsum + SQ_W'(v * v);
            acc_count = acc_count + 1'b1;
        end
        if (last) begin
            n        = acc_count;
            total    = acc_sum;
            smag     = (total < 0) ? -total : total;
            mean_mag = (smag << FRAC) / n;
            spread   = (128'(n) * 128'(acc_sqsum) - 128'(smag) * 128'(smag)) << (2 * FRAC);
            res.mean     = MEAN_W'((total < 0) ? -mean_mag : mean_mag);
            res.dev      = STD_W'(isqrt128(spread) / n);
            res.count    = n;
            res.overflow = acc_overflow;
            done         = 1'b1;
            stats_clear();
        end
    endfunction

    function automatic void add_row(input logic signed [SW-1:0] s, input logic last,
                                    input logic pinned, input t_stats value);
        t_dir_row r;
        r.sample = s;
        r.last   = last;
        r.pinned = pinned;
        r.value  = value;
        dir_rows.push_back(r);
    endfunction

    function automatic logic signed [SW-1:0] pick_sample(input t_set_flavor flavor,
                                                         input logic signed [SW-1:0] base);
        case (flavor)
            FL_FULL: begin
                return SW'($urandom);
            end
            FL_NARROW: begin
                return SW'(int'($urandom_range(32)) - 16);
            end
            FL_EDGE: begin
                case ($urandom_range(6))
                    0: return -16'sd32768;
                    1: return -16'sd32767;
                    2: return -16'sd1;
                    3: return 16'sd0;
                    4: return 16'sd1;
                    5: return 16'sd32766;
                    default: return 16'sd32767;
                endcase
            end
            default: begin
                return base;
            end
        endcase
    endfunction

    task automatic send_sample(input logic signed [SW-1:0] s, input logic last,
                               input logic pinned, input t_stats value);
        @(negedge i_clk);
        start         <= 1'b1;
        i_sample      <= s;
        i_last_sample <= last;
        pin_valid     <= pinned;
        pin_value     <= value;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        samples_sent++;
    endtask

    // Random sender gap; junk on the data ports must be ignored while idle.
    task automatic sender_gap(input int pct);
        while (int'($urandom_range(99)) < pct) begin
            @(negedge i_clk);
            start         <= 1'b0;
            i_sample      <= SW'($urandom);
            i_last_sample <= 1'($urandom_range(1));
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("Timeout at cycle %0d, %0d results outstanding",
                     cycle_count, expected_stats.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Results are checked before the transfer of the same edge is predicted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (expected_stats.size() == 0) begin
                    $error("result with no expectation pending");
                    fail_count++;
                end else begin
                    want = expected_stats.pop_front();
                    if (o_mean_value !== want.mean) begin
                        $error("mean_value: expected %0d, got %0d",
                               $signed(want.mean), $signed(o_mean_value));
                        fail_count++;
                    end
                    if (o_std_dev !== want.dev) begin
                        $error("std_dev: expected %0d, got %0d", want.dev, o_std_dev);
                        fail_count++;
                    end
                    if (o_sample_count !== want.count) begin
                        $error("sample_count: expected %0d, got %0d",
                               want.count, o_sample_count);
                        fail_count++;
                    end
                    if (o_count_overflow !== want.overflow) begin
                        $error("count_overflow: expected %0d, got %0d",
                               want.overflow, o_count_overflow);
                        fail_count++;
                    end
                    results_seen++;
                end
            end
            if (start && busy === 1'b0) begin
                stats_step(i_sample, i_last_sample, step_done, step_res);
                if (step_done) begin
                    expected_stats.push_back(pin_valid ? pin_value : step_res);
                end
            end
        end
    end

    initial begin
        int          phase_gap[3];
        int          p;
        int          k;
        int          len;
        int          phase_items;
        int          oversized;
        t_set_flavor flavor;
        logic signed [SW-1:0] base;

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_sample      = '0;
        i_last_sample = 1'b0;
        pin_valid     = 1'b0;
        pin_value     = '0;
        fail_count    = 0;
        results_seen  = 0;
        samples_sent  = 0;
        cycle_count   = 0;
        oversized     = 0;
        phase_gap     = '{0, 62, 25};
        stats_clear();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single samples at the limits, pairs with exact answers, and small
        // sets where the mean truncates toward zero.
        add_row(16'sd0,      1'b1, 1'b1, '{mean: 0,        dev: 0,       count: 1, overflow: 0});
        add_row(16'sd32767,  1'b1, 1'b1, '{mean: 8388352,  dev: 0,       count: 1, overflow: 0});
        add_row(-16'sd32768, 1'b1, 1'b1, '{mean: -8388608, dev: 0,       count: 1, overflow: 0});
        add_row(-16'sd1,     1'b1, 1'b1, '{mean: -256,     dev: 0,       count: 1, overflow: 0});
        add_row(16'sd32767,  1'b0, 1'b0, '0);
        add_row(-16'sd32768, 1'b1, 1'b1, '{mean: -128,     dev: 8388480, count: 2, overflow: 0});
        add_row(16'sd5,      1'b0, 1'b0, '0);
        add_row(16'sd7,      1'b1, 1'b1, '{mean: 1536,     dev: 256,     count: 2, overflow: 0});
        add_row(16'sd1,      1'b0, 1'b0, '0);
        add_row(-16'sd1,     1'b1, 1'b1, '{mean: 0,        dev: 256,     count: 2, overflow: 0});
        add_row(16'sd1,      1'b0, 1'b0, '0);
        add_row(16'sd2,      1'b0, 1'b0, '0);
        add_row(16'sd2,      1'b1, 1'b0, '0);
        add_row(-16'sd1,     1'b0, 1'b0, '0);
        add_row(-16'sd1,     1'b0, 1'b0, '0);
        add_row(16'sd0,      1'b1, 1'b0, '0);
        add_row(16'h5555,    1'b1, 1'b0, '0);
        add_row(16'hAAAA,    1'b1, 1'b0, '0);
        add_row(-16'sd32768, 1'b0, 1'b0, '0);
        add_row(-16'sd32768, 1'b0, 1'b0, '0);
        add_row(16'sd32767,  1'b1, 1'b0, '0);
        foreach (dir_rows[i]) begin
            send_sample(dir_rows[i].sample, dir_rows[i].last, dir_rows[i].pinned,
                        dir_rows[i].value);
        end

        // Oversized set of alternating extremes: the count saturates, the
        // extra samples, the flagged one included, are dropped, and the kept
        // samples give the widest spread, the same answer as the extreme pair.
        for (k = 0; k <= MAXS + 1; k++) begin
            send_sample(k[0] ? -16'sd32768 : 16'sd32767, k == MAXS + 1, k == MAXS + 1,
                        '{mean: -128, dev: 8388480, count: MAXS, overflow: 1});
        end
        oversized++;

        for (p = 0; p < 3; p++) begin
            phase_items = 0;
            while (phase_items < 234) begin
                k = $urandom_range(99);
                len = (k < 70) ? $urandom_range(8, 1) :
                      (k < 95) ? $urandom_range(40, 9) : $urandom_range(200, 41);
                flavor = t_set_flavor'($urandom_range(3));
                base   = SW'($urandom);
                for (k = 0; k < len; k++) begin
                    sender_gap(phase_gap[p]);
                    send_sample(pick_sample(flavor, base), k == len - 1, 1'b0, '0);
                end
                phase_items += len;
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (expected_stats.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("Sent %0d samples in directed, oversized (%0d) and random sets;",
                 samples_sent, oversized);
        $display("checked %0d results with sender gaps of 0, 62 and 25 percent.",
                 results_seen);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
